[hdl/hbrd_pkg.sv]
package hbrd_pkg;

  typedef enum logic [4:0] {
    PH_TOTAL, PH_V6_X, PH_V6_Y, PH_V6_C, PH_XOFF, PH_YOFF, PH_SHORT, PH_TYPE,
    PH_ROWS, PH_ROW_Y, PH_COLS, PH_COL_X, PH_COL_C, PH_POINTS, PH_WIDTH,
    PH_DENSE_C, PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    CNT_SHORT, CNT_FLOAT
  } cnt_kind_e;

  localparam logic [3:0] PlainTripleVersion = 4'd7;
  localparam logic [15:0] ShortSkipCode = 16'h8000;
  localparam logic [0:0] CfgFormatVersion = 1'b0;
  localparam logic [0:0] CfgChromosomeId = 1'b1;
  localparam int unsigned QueueDepth = 2;

  // One classified record waiting for count conversion.
  typedef struct packed {
    logic [9:0]  chrom;
    logic [31:0] bin_x;
    logic [31:0] bin_y;
    logic [31:0] raw;
    cnt_kind_e   kind;
  } rec_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic float_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] float_to_int(input logic [31:0] b);
    logic [7:0]  ex;
    logic [31:0] mag;
    logic [7:0]  e;
    ex = b[30:23];
    e = ex - 8'd127;
    mag = {8'd0, 1'b1, b[22:0]};
    if (float_is_nan(b) || ex < 8'd127) begin
      return 32'd0;
    end
    if (e >= 8'd31) begin
      return b[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    if (e >= 8'd23) begin
      mag = mag << (e - 8'd23);
    end else begin
      mag = mag >> (8'd23 - e);
    end
    return b[31] ? (32'd0 - mag) : mag;
  endfunction

endpackage

[hdl/hbrd_if.sv]
interface hbrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;
  modport source (output valid, data_byte, block_start, input ready);
  modport sink (input valid, data_byte, block_start, output ready);
endinterface

interface hbrd_rec_if;
  logic        valid;
  logic        ready;
  logic [9:0]  chromosome;
  logic [31:0] bin_x;
  logic [31:0] bin_y;
  logic [31:0] contact_count;
  modport source (output valid, chromosome, bin_x, bin_y, contact_count, input ready);
  modport sink (input valid, chromosome, bin_x, bin_y, contact_count, output ready);
endinterface

interface hbrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/hic_block_record_decoder.sv]
// Contact block record decoder. Takes one byte of a decompressed contact
// block per transfer (block_start on the first byte) and delivers one
// (chromosome, bin_x, bin_y, contact_count) record per completed count
// field, skipping dense short -32768 entries and dense NaN floats. The
// parser front end accepts one byte per cycle; records pass through a
// two-entry queue to a back end that converts the count and holds the
// result in an output register, so a stalled consumer only holds off
// input once the queue is full. Configuration must be written through
// the cfg channel while idle; the block itself does not enforce it.
module hic_block_record_decoder
  import hbrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hbrd_cfg_if.sink cfg,
  hbrd_byte_if.sink in,
  hbrd_rec_if.source out
);

  logic [3:0] version_q;
  logic [9:0] chrom_q;
  logic       p_valid, q_ready, q_valid, c_ready;
  rec_t       p_rec, q_rec;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 4'd8;
      chrom_q <= 10'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgFormatVersion: version_q <= cfg.data[3:0];
        CfgChromosomeId: chrom_q <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  hbrd_parser u_parser (
    .clk_i, .rst_ni,
    .in_valid_i(in.valid), .in_ready_o(in.ready),
    .byte_i(in.data_byte), .start_i(in.block_start),
    .version_i(version_q), .chrom_i(chrom_q),
    .rec_valid_o(p_valid), .rec_ready_i(q_ready), .rec_o(p_rec)
  );

  hbrd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(p_valid), .wr_ready_o(q_ready), .wr_rec_i(p_rec),
    .rd_valid_o(q_valid), .rd_ready_i(c_ready), .rd_rec_o(q_rec)
  );

  hbrd_convert u_convert (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(c_ready), .rec_i(q_rec), .out(out)
  );

endmodule

[hdl/hbrd_parser.sv]
module hbrd_parser
  import hbrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_i,
  input  logic       start_i,
  input  logic [3:0] version_i,
  input  logic [9:0] chrom_i,
  output logic       rec_valid_o,
  input  logic       rec_ready_i,
  output rec_t       rec_o
);

  phase_e      phase_q, phase_d, ph;
  logic [31:0] shift_q, shift_d, sh;
  logic [1:0]  bidx_q, bidx_d, bi;
  logic [31:0] recs_q, recs_d;
  logic [31:0] xoff_q, xoff_d, yoff_q, yoff_d;
  logic        short_q, short_d;
  logic [15:0] rows_q, rows_d, cols_q, cols_d;
  logic [31:0] rowbin_q, rowbin_d, pbx_q, pbx_d, pts_q, pts_d;
  logic [15:0] gw_q, gw_d, gcol_q, gcol_d;
  logic [31:0] grow_q, grow_d;
  logic [1:0]  len;
  logic [31:0] v, nb;
  logic        fire, done, emit;
  logic [15:0] absw, rl;

  // A byte is only taken when the queue can hold any record it produces.
  assign in_ready_o = rec_ready_i;
  assign fire = in_valid_i && in_ready_o;
  assign rec_valid_o = fire && emit;

  always_comb begin
    ph = start_i ? PH_TOTAL : phase_q;
    sh = start_i ? 32'd0 : shift_q;
    bi = start_i ? 2'd0 : bidx_q;
    phase_d = ph; shift_d = sh; bidx_d = bi;
    recs_d = start_i ? 32'd0 : recs_q;
    xoff_d = start_i ? 32'd0 : xoff_q;
    yoff_d = start_i ? 32'd0 : yoff_q;
    short_d = start_i ? 1'b0 : short_q;
    rows_d = start_i ? 16'd0 : rows_q;
    cols_d = start_i ? 16'd0 : cols_q;
    rowbin_d = start_i ? 32'd0 : rowbin_q;
    pbx_d = start_i ? 32'd0 : pbx_q;
    pts_d = start_i ? 32'd0 : pts_q;
    gw_d = start_i ? 16'd0 : gw_q;
    gcol_d = start_i ? 16'd0 : gcol_q;
    grow_d = start_i ? 32'd0 : grow_q;
    emit = 1'b0;
    rec_o = '{chrom: chrom_i, bin_x: pbx_d, bin_y: rowbin_d, raw: 32'd0, kind: CNT_FLOAT};
    case (ph)
      PH_SHORT, PH_TYPE: len = 2'd1;
      PH_ROWS, PH_ROW_Y, PH_COLS, PH_COL_X, PH_WIDTH: len = 2'd2;
      PH_COL_C, PH_DENSE_C: len = short_d ? 2'd2 : 2'd0;
      default: len = 2'd0;
    endcase
    nb = {24'd0, byte_i} << {bi, 3'b000};
    v = sh | nb;
    done = (bi + 2'd1) == len;
    absw = gw_d[15] ? (16'd0 - gw_d) : gw_d;
    if (absw == 16'd0) absw = 16'h8000;
    rl = rows_d - 16'd1;
    if (ph != PH_IDLE) begin
      shift_d = v;
      bidx_d = bi + 2'd1;
      if (done) begin
        shift_d = 32'd0;
        bidx_d = 2'd0;
        case (ph)
          PH_TOTAL: begin
            recs_d = v;
            if (version_i < PlainTripleVersion)
              phase_d = (v != 0 && !v[31]) ? PH_V6_X : PH_IDLE;
            else phase_d = PH_XOFF;
          end
          PH_V6_X: begin pbx_d = v; phase_d = PH_V6_Y; end
          PH_V6_Y: begin rowbin_d = v; phase_d = PH_V6_C; end
          PH_V6_C: begin
            emit = 1'b1;
            rec_o = '{chrom: chrom_i, bin_x: pbx_d, bin_y: rowbin_d, raw: v, kind: CNT_FLOAT};
            recs_d = recs_d - 32'd1;
            phase_d = (recs_d == 0) ? PH_IDLE : PH_V6_X;
          end
          PH_XOFF: begin xoff_d = v; phase_d = PH_YOFF; end
          PH_YOFF: begin yoff_d = v; phase_d = PH_SHORT; end
          PH_SHORT: begin short_d = (v == 0); phase_d = PH_TYPE; end
          PH_TYPE: phase_d = (v == 1) ? PH_ROWS : ((v == 2) ? PH_POINTS : PH_IDLE);
          PH_ROWS: begin
            rows_d = v[15:0];
            phase_d = (v != 0 && !v[15]) ? PH_ROW_Y : PH_IDLE;
          end
          PH_ROW_Y: begin rowbin_d = sext16(v[15:0]) + yoff_d; phase_d = PH_COLS; end
          PH_COLS: begin
            cols_d = v[15:0];
            if (v != 0 && !v[15]) phase_d = PH_COL_X;
            else begin rows_d = rl; phase_d = (rl == 0) ? PH_IDLE : PH_ROW_Y; end
          end
          PH_COL_X: begin pbx_d = xoff_d + sext16(v[15:0]); phase_d = PH_COL_C; end
          PH_COL_C: begin
            emit = 1'b1;
            rec_o = '{chrom: chrom_i, bin_x: pbx_d, bin_y: rowbin_d, raw: v,
                      kind: short_d ? CNT_SHORT : CNT_FLOAT};
            cols_d = cols_d - 16'd1;
            if (cols_d == 0) begin
              rows_d = rl; phase_d = (rl == 0) ? PH_IDLE : PH_ROW_Y;
            end else phase_d = PH_COL_X;
          end
          PH_POINTS: begin
            pts_d = v;
            phase_d = (v != 0 && !v[31]) ? PH_WIDTH : PH_IDLE;
          end
          PH_WIDTH: begin
            gw_d = v[15:0]; gcol_d = 16'd0; grow_d = 32'd0;
            phase_d = (v == 0) ? PH_IDLE : PH_DENSE_C;
          end
          PH_DENSE_C: begin
            emit = short_d ? (v[15:0] != ShortSkipCode) : !float_is_nan(v);
            rec_o = '{chrom: chrom_i, bin_x: xoff_d + {16'd0, gcol_d},
                      bin_y: yoff_d + grow_d, raw: v,
                      kind: short_d ? CNT_SHORT : CNT_FLOAT};
            gcol_d = gcol_d + 16'd1;
            if (gcol_d >= absw) begin
              gcol_d = 16'd0;
              grow_d = gw_d[15] ? grow_d - 32'd1 : grow_d + 32'd1;
            end
            pts_d = pts_d - 32'd1;
            if (pts_d == 0) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOTAL; shift_q <= '0; bidx_q <= '0; recs_q <= '0;
      xoff_q <= '0; yoff_q <= '0; short_q <= 1'b0; rows_q <= '0; cols_q <= '0;
      rowbin_q <= '0; pbx_q <= '0; pts_q <= '0; gw_q <= '0; gcol_q <= '0;
      grow_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d; shift_q <= shift_d; bidx_q <= bidx_d; recs_q <= recs_d;
      xoff_q <= xoff_d; yoff_q <= yoff_d; short_q <= short_d; rows_q <= rows_d;
      cols_q <= cols_d; rowbin_q <= rowbin_d; pbx_q <= pbx_d; pts_q <= pts_d;
      gw_q <= gw_d; gcol_q <= gcol_d; grow_q <= grow_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> fire) else $error("record without byte transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !start_i && phase_q == PH_IDLE) |-> !rec_valid_o)
    else $error("record after block end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (bidx_q == 2'd0)) else $error("idle with partial field");

endmodule

[hdl/hbrd_queue.sv]
module hbrd_queue
  import hbrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  rec_t wr_rec_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output rec_t rd_rec_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  rec_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != QueueDepth[PtrW:0];
  assign rd_valid_o = cnt_q != '0;
  assign rd_rec_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{PtrW{1'b0}}, wr} - {{PtrW{1'b0}}, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueDepth[PtrW:0]) else $error("queue overflow");

endmodule

[hdl/hbrd_convert.sv]
module hbrd_convert
  import hbrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rec_t rec_i,
  hbrd_rec_if.source out
);

  logic valid_q;

  assign in_ready_o = !valid_q || out.ready;
  assign out.valid = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      out.chromosome <= rec_i.chrom;
      out.bin_x <= rec_i.bin_x;
      out.bin_y <= rec_i.bin_y;
      case (rec_i.kind)
        CNT_SHORT: out.contact_count <= sext16(rec_i.raw[15:0]);
        default: out.contact_count <= float_to_int(rec_i.raw);
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out.valid && !out.ready) |=> out.valid) else $error("result dropped");

endmodule
